/* rtl/core/rtdct_pkg.sv */
package rtdct_pkg;

  // Square-root chain geometry: 62-bit radicand, one root bit per cell
  localparam int ROOT_W = 31;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  // Pipeline depth around the root chain
  localparam int FRONT_STG = 3;
  localparam int SCALE_STG = 3;
  localparam int TEMP_W    = 21;

  // Discriminant terms: N = K_SUM * 2^code_bits - B_TERM * code * rref
  localparam logic [63:0] K_SUM  = 64'd17584808890000;
  localparam logic [63:0] B_TERM = 64'd1443750000;

  // Root to temperature: t = round((A_SCALED - S) / DIV_ROUND)
  localparam logic signed [32:0] A_SCALED    = 33'sd2001049600;
  localparam logic [31:0]        DIV_ROUND   = 32'd2310;
  localparam logic [31:0]        DIV_HALF    = 32'd1155;
  localparam logic [63:0]        RECIP       = 64'd3807832477;
  localparam int                 RECIP_SHIFT = 43;

  // Configuration register indexes
  localparam logic [1:0] REG_REF_RES = 2'd0;
  localparam logic [1:0] REG_CORR_EN = 2'd1;

  // Calibration windows, inclusive bounds in 1/256 degree C
  localparam int NUM_WIN = 16;

  localparam logic signed [TEMP_W-1:0] WIN_LO [NUM_WIN] = '{
    -21'sd32256, -21'sd26112, -21'sd19712, -21'sd13312, -21'sd6784, -21'sd384,
    21'sd6144, 21'sd12800, 21'sd19456, 21'sd25856, 21'sd32768, 21'sd39680,
    21'sd46592, 21'sd52736, 21'sd60416, 21'sd67328
  };

  localparam logic signed [TEMP_W-1:0] WIN_HI [NUM_WIN] = '{
    -21'sd31744, -21'sd25344, -21'sd19200, -21'sd12800, -21'sd6272, 21'sd512,
    21'sd6656, 21'sd13312, 21'sd19968, 21'sd26624, 21'sd33280, 21'sd40064,
    21'sd46976, 21'sd54272, 21'sd60928, 21'sd67891
  };

  localparam logic signed [TEMP_W-1:0] WIN_ADD [NUM_WIN] = '{
    21'sd161, 21'sd256, 21'sd282, 21'sd261, 21'sd210, 21'sd0,
    21'sd205, 21'sd243, 21'sd192, 21'sd161, 21'sd46, 21'sd154,
    21'sd251, 21'sd294, 21'sd474, 21'sd320
  };

  // Windows that force the temperature to zero (the one around 0 degrees)
  localparam logic [NUM_WIN-1:0] WIN_ZERO = 16'h0020;

endpackage

/* rtl/core/rtd_code_to_temperature.sv */
// Throughput: one item per cycle while the output is not stalled, set by the 31-cell
//   square-root chain and the three-stage multiply front end, each stage taking a new
//   item every cycle unless a stalled result holds it.
// Reset (rst_n, synchronous, active low) empties every pipeline stage and loads
//   reference_resistance = 6880 and correction_enable = 1.
module rtd_code_to_temperature import rtdct_pkg::*; #(
  parameter int CODE_BITS = 15
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input item channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [15:0]              in_rtd_register,
  // result item channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] out_temperature,
  output logic                     out_no_root,
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  // Stage map: front multiply stages, one stage per root bit, scale stages,
  // then the output register with the calibration windows.
  localparam int CELL0 = FRONT_STG;
  localparam int SCL0  = FRONT_STG + ROOT_W;
  localparam int NSTG  = FRONT_STG + ROOT_W + SCALE_STG + 1;

  logic [15:0]     ref_r;
  logic            corr_en_r;
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;

  logic [RAD_W-1:0]  front_rad;
  logic              front_flag;
  logic [REM_W-1:0]  rem_c  [0:ROOT_W];
  logic [ROOT_W-1:0] root_c [0:ROOT_W];
  logic [RAD_W-1:0]  rad_c  [0:ROOT_W];
  logic              flag_c [0:ROOT_W];

  logic signed [TEMP_W-1:0] t_s;
  logic                     flag_s;
  logic signed [TEMP_W-1:0] temp_nxt, temp_r;
  logic                     no_root_r;
  logic                     hit;

  // Configuration: always ready, unknown indexes drop the write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r     <= 16'd6880;
      corr_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REF_RES: ref_r     <= cfg_data;
        REG_CORR_EN: corr_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Flow control: a stage may load unless it and every stage after it are
  // full while the output is held. Bubbles close up behind a stalled result.
  genvar g;
  generate
    for (g = 0; g < NSTG; g++) begin : g_rdy
      assign rdy[g] = !out_stall || !(&v_r[NSTG-1:g]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          v_r[i] <= (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NSTG-1];

  // Code times reference, then the discriminant and its sign
  rtdct_front #(
    .CODE_BITS(CODE_BITS)
  ) u_front (
    .clk         (clk),
    .en          (rdy[FRONT_STG-1:0]),
    .rtd_register(in_rtd_register),
    .ref_res     (ref_r),
    .rad_r       (front_rad),
    .flag_r      (front_flag)
  );

  // Square root: each cell settles one root bit and hands on to the next
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;
  assign rad_c[0]  = front_rad;
  assign flag_c[0] = front_flag;

  generate
    for (g = 0; g < ROOT_W; g++) begin : g_cell
      rtdct_sqrt_cell u_cell (
        .clk    (clk),
        .en     (rdy[CELL0 + g]),
        .rem_in (rem_c[g]),
        .root_in(root_c[g]),
        .rad_in (rad_c[g]),
        .flag_in(flag_c[g]),
        .rem_r  (rem_c[g+1]),
        .root_r (root_c[g+1]),
        .rad_r  (rad_c[g+1]),
        .flag_r (flag_c[g+1])
      );
    end
  endgenerate

  // Root to temperature in 1/256 degree, rounded half away from zero
  rtdct_scale u_scale (
    .clk    (clk),
    .en     (rdy[SCL0 +: SCALE_STG]),
    .root   (root_c[ROOT_W]),
    .flag_in(flag_c[ROOT_W]),
    .t_r    (t_s),
    .flag_r (flag_s)
  );

  // Calibration: first matching window wins; no root forces zero
  always_comb begin
    hit      = 1'b0;
    temp_nxt = flag_s ? '0 : t_s;
    if (!flag_s && corr_en_r) begin
      for (int i = 0; i < NUM_WIN; i++) begin
        if (!hit && t_s >= WIN_LO[i] && t_s <= WIN_HI[i]) begin
          hit      = 1'b1;
          temp_nxt = WIN_ZERO[i] ? '0 : t_s + WIN_ADD[i];
        end
      end
    end
  end

  // Output register: hold while a valid result is stalled
  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      temp_r    <= temp_nxt;
      no_root_r <= flag_s;
    end
  end

  assign out_temperature = temp_r;
  assign out_no_root     = no_root_r;

endmodule

/* rtl/core/rtdct_front.sv */
module rtdct_front import rtdct_pkg::*; #(
  parameter int CODE_BITS = 15
) (
  input  logic                 clk,
  input  logic [FRONT_STG-1:0] en,
  input  logic [15:0]          rtd_register,
  input  logic [15:0]          ref_res,
  output logic [RAD_W-1:0]     rad_r,
  output logic                 flag_r
);

  localparam int QW  = CODE_BITS + 16;
  localparam int SHL = 18 - CODE_BITS;
  localparam logic [63:0] K_SH = K_SUM << CODE_BITS;

  logic [CODE_BITS-1:0] code;
  logic [QW-1:0]        q_r, q_nxt;
  logic [63:0]          bq_r, bq_nxt;
  logic signed [63:0]   disc;
  logic [63:0]          disc_sh;
  logic [RAD_W-1:0]     rad_nxt;
  logic                 flag_nxt;

  // Drop the fault bit
  assign code = rtd_register[15 -: CODE_BITS];

  always_comb begin
    q_nxt    = QW'(code) * QW'(ref_res);
    bq_nxt   = 64'(q_r) * B_TERM;
    disc     = signed'(K_SH - bq_r);
    disc_sh  = 64'(disc) << SHL;
    flag_nxt = disc[63];
    rad_nxt  = flag_nxt ? '0 : disc_sh[RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_r <= q_nxt;
    end
    if (en[1]) begin
      bq_r <= bq_nxt;
    end
    if (en[2]) begin
      rad_r  <= rad_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

/* rtl/core/rtdct_sqrt_cell.sv */
module rtdct_sqrt_cell import rtdct_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [ROOT_W-1:0] root_in,
  input  logic [RAD_W-1:0]  rad_in,
  input  logic              flag_in,
  output logic [REM_W-1:0]  rem_r,
  output logic [ROOT_W-1:0] root_r,
  output logic [RAD_W-1:0]  rad_r,
  output logic              flag_r
);

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [RAD_W-1:0]  rad_nxt;

  // One restoring step: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh   = {rem_in, rad_in[RAD_W-1 -: 2]};
    trial    = (REM_W+2)'({root_in, 2'b01});
    ge       = rem_sh >= trial;
    diff     = rem_sh - trial;
    rem_nxt  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_nxt = {root_in[ROOT_W-2:0], ge};
    rad_nxt  = {rad_in[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
      flag_r <= flag_in;
    end
  end

endmodule

/* rtl/core/rtdct_scale.sv */
module rtdct_scale import rtdct_pkg::*; (
  input  logic                     clk,
  input  logic [SCALE_STG-1:0]     en,
  input  logic [ROOT_W-1:0]        root,
  input  logic                     flag_in,
  output logic signed [TEMP_W-1:0] t_r,
  output logic                     flag_r
);

  logic signed [32:0]  num;
  logic [32:0]         absn;
  logic                neg_a_nxt;
  logic [31:0]         mag_a_nxt;
  logic [31:0]         mag_a_r, mag_b_r;
  logic                neg_a_r, neg_b_r;
  logic                flag_a_r, flag_b_r;
  logic [63:0]         prod;
  logic [TEMP_W-1:0]   q0_nxt, q0_r;
  logic [31:0]         rem;
  logic [TEMP_W-1:0]   q;
  logic signed [TEMP_W-1:0] t_nxt;

  always_comb begin
    // Stage a: signed numerator, magnitude with half divisor for rounding
    num       = A_SCALED - signed'({2'b00, root});
    neg_a_nxt = num[32];
    absn      = neg_a_nxt ? 33'(-num) : 33'(num);
    mag_a_nxt = absn[31:0] + DIV_HALF;
    // Stage b: quotient estimate by reciprocal, low by at most one
    prod      = 64'(mag_a_r) * RECIP;
    q0_nxt    = prod[RECIP_SHIFT +: TEMP_W];
    // Stage c: correct and apply sign
    rem       = mag_b_r - 32'(q0_r) * DIV_ROUND;
    q         = q0_r + TEMP_W'(rem >= DIV_ROUND);
    t_nxt     = neg_b_r ? -signed'(q) : signed'(q);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag_a_r  <= mag_a_nxt;
      neg_a_r  <= neg_a_nxt;
      flag_a_r <= flag_in;
    end
    if (en[1]) begin
      q0_r     <= q0_nxt;
      mag_b_r  <= mag_a_r;
      neg_b_r  <= neg_a_r;
      flag_b_r <= flag_a_r;
    end
    if (en[2]) begin
      t_r    <= t_nxt;
      flag_r <= flag_b_r;
    end
  end

endmodule
